FILE: rtl/ttp_pkg.sv
// Shared types and constants for the task time profiler.
`default_nettype none

package ttp_pkg;

    localparam int TIMER_PERIOD = 7500;
    localparam int TASKS = 4;
    localparam int TASK_IW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam logic [4:0] TASK_LIMIT = 5'(TASKS);

    localparam logic [31:0] US_PER_MS = 32'd1000;
    localparam logic [7:0] SLOW_RESET = 8'd10;

    localparam int FRAC_W = 13;
    localparam int FRAC_SHIFT = 30;
    localparam int FRAC_PROD_W = FRAC_SHIFT + FRAC_W;
    localparam longint FRAC_MULT =
        ((longint'(1000) << FRAC_SHIFT) + longint'(TIMER_PERIOD) - 1) / longint'(TIMER_PERIOD);
    localparam logic [FRAC_W-1:0] FRAC_FULL = FRAC_W'(1000);

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam int CFG_ADDR_W = 3;
    localparam logic [0:0] REG_TICKS_PER_SLOW = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  task_id;
        logic [12:0] timer_count;
        logic        match_pending;
    } t_in_word;

    typedef struct packed {
        logic [31:0] timestamp_us;
        logic [31:0] task_time;
        logic [31:0] peak_time;
        logic        slow_period_due;
        logic        accepted;
    } t_out_word;

    typedef struct packed {
        logic [31:0] timestamp_us;
        logic        slow_period_due;
    } t_time_info;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [3:0]  task_id;
        logic [31:0] timestamp_us;
    } t_task_req;

    typedef struct packed {
        logic [31:0] task_time;
        logic [31:0] peak_time;
        logic        accepted;
    } t_task_rsp;

endpackage

`default_nettype wire

FILE: rtl/ttp_frac.sv
// Sub-millisecond fraction of the timestamp from the sampled timer count.
`default_nettype none

module ttp_frac (
    input  var ttp_pkg::t_in_word              i_word,
    output logic [ttp_pkg::FRAC_W-1:0]         o_frac
);

    logic [ttp_pkg::FRAC_PROD_W-1:0] w_prod;

    assign w_prod = ttp_pkg::FRAC_PROD_W'(i_word.timer_count)
                  * ttp_pkg::FRAC_PROD_W'(ttp_pkg::FRAC_MULT);

    assign o_frac = i_word.match_pending ? ttp_pkg::FRAC_FULL
                                         : w_prod[ttp_pkg::FRAC_SHIFT +: ttp_pkg::FRAC_W];

endmodule

`default_nettype wire

FILE: rtl/ttp_timebase.sv
// Millisecond timebase, slow-period divider and timestamp adder.
`default_nettype none

module ttp_timebase (
    input  var logic                           i_clk,
    input  var logic                           i_rst_n,
    input  var logic                           i_advance,
    input  var logic                           i_tick,
    input  var logic [ttp_pkg::FRAC_W-1:0]     i_frac,
    input  var logic [7:0]                     i_ticks_per_slow,
    output ttp_pkg::t_time_info                o_time
);

    logic [31:0] r_ms_us;
    logic [31:0] r_ms_us_next;
    logic [7:0]  r_sub;
    logic [7:0]  n_sub;
    logic [31:0] w_base;
    logic        w_wrap;

    assign n_sub  = r_sub + 8'd1;
    assign w_wrap = (n_sub >= i_ticks_per_slow);
    assign w_base = i_tick ? r_ms_us_next : r_ms_us;

    assign o_time.timestamp_us    = w_base + 32'(i_frac);
    assign o_time.slow_period_due = i_tick && w_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_us      <= '0;
            r_ms_us_next <= ttp_pkg::US_PER_MS;
            r_sub        <= '0;
        end else if (i_advance && i_tick) begin
            r_ms_us      <= r_ms_us_next;
            r_ms_us_next <= r_ms_us_next + ttp_pkg::US_PER_MS;
            r_sub        <= w_wrap ? 8'd0 : n_sub;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ttp_task_table.sv
// Per-task start times and peak execution times.
`default_nettype none

module ttp_task_table (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var ttp_pkg::t_task_req  i_req,
    output ttp_pkg::t_task_rsp      o_rsp
);

    logic [31:0] r_start [ttp_pkg::TASKS];
    logic [31:0] r_peak  [ttp_pkg::TASKS];

    logic [ttp_pkg::TASK_IW-1:0] w_idx;
    logic        w_is_start;
    logic        w_is_end;
    logic        w_hit;
    logic [31:0] w_diff;
    logic [31:0] w_peak_new;

    assign w_idx      = i_req.task_id[ttp_pkg::TASK_IW-1:0];
    assign w_is_start = (i_req.kind == ttp_pkg::KIND_START);
    assign w_is_end   = (i_req.kind == ttp_pkg::KIND_END);
    assign w_hit      = (w_is_start || w_is_end) && ({1'b0, i_req.task_id} < ttp_pkg::TASK_LIMIT);
    assign w_diff     = i_req.timestamp_us - r_start[w_idx];
    assign w_peak_new = (w_is_end && (w_diff > r_peak[w_idx])) ? w_diff : r_peak[w_idx];

    assign o_rsp.accepted  = w_hit;
    assign o_rsp.task_time = (w_hit && w_is_end) ? w_diff : 32'd0;
    assign o_rsp.peak_time = w_hit ? w_peak_new : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ttp_pkg::TASKS; i++) begin
                r_start[i] <= '0;
                r_peak[i]  <= '0;
            end
        end else if (i_req.valid && w_hit) begin
            if (w_is_start) begin
                r_start[w_idx] <= i_req.timestamp_us;
            end
            r_peak[w_idx] <= w_peak_new;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/task_time_profiler_unit.sv
// Task time profiler top level: input stage, config register, output register.
//
// Input channel: i_in_valid / o_in_stall carry one word per item: a millisecond
// tick, a task start or a task end, with task index and sampled timer count.
// Output channel: o_out_valid / i_out_stall return one word per item with the
// microsecond timestamp, task time, peak time, slow-period flag and accept flag.
// Configuration: APB-style port, one register (ticks per slow period) at
// byte address 0; write it only while no item is in flight.
// Path: an accepted word loads the input register; its result then loads the
// result register, which drives the output.
// Throughput: one word per cycle unless the receiver stalls; the timestamp adder
// and the task table update form the single stage between the two registers.
// Reset: millisecond and sub-tick counters, start and peak tables clear to
// zero, the register returns to 10, and both channels empty.
// Stall: while the receiver stalls, the result holds; the input register
// keeps one more word, after which o_in_stall rises until the output drains.
`default_nettype none

module task_time_profiler_unit (
    input  var logic                                i_clk,
    input  var logic                                i_rst_n,
    input  var logic                                i_in_valid,
    output logic                                    o_in_stall,
    input  var ttp_pkg::t_in_word                   i_in_word,
    output logic                                    o_out_valid,
    input  var logic                                i_out_stall,
    output ttp_pkg::t_out_word                      o_out_word,
    input  var logic                                psel,
    input  var logic                                penable,
    input  var logic                                pwrite,
    input  var logic [ttp_pkg::CFG_ADDR_W-1:0]      paddr,
    input  var logic [31:0]                         pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    logic                          r_s1_valid;
    ttp_pkg::t_in_word             r_s1_word;
    logic [ttp_pkg::FRAC_W-1:0]    r_s1_frac;
    logic                          r_out_valid;
    ttp_pkg::t_out_word            r_out_word;
    ttp_pkg::t_out_word            n_out_word;
    logic [7:0]                    r_ticks_per_slow;

    logic [ttp_pkg::FRAC_W-1:0]    w_frac;
    logic                          w_advance;
    logic                          w_load;
    logic                          w_tick;
    logic                          w_cfg_sel;
    ttp_pkg::t_time_info           w_time;
    ttp_pkg::t_task_req            w_req;
    ttp_pkg::t_task_rsp            w_rsp;

    assign w_advance  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign w_load     = !r_s1_valid || w_advance;
    assign o_in_stall = r_s1_valid && !w_advance;
    assign w_tick     = (r_s1_word.kind == ttp_pkg::KIND_TICK);

    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[ttp_pkg::CFG_ADDR_W-1:2] == ttp_pkg::REG_TICKS_PER_SLOW);
    assign prdata    = w_cfg_sel ? {24'd0, r_ticks_per_slow} : 32'd0;

    ttp_frac u_frac (
        .i_word (i_in_word),
        .o_frac (w_frac)
    );

    ttp_timebase u_timebase (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (w_advance),
        .i_tick           (w_tick),
        .i_frac           (r_s1_frac),
        .i_ticks_per_slow (r_ticks_per_slow),
        .o_time           (w_time)
    );

    assign w_req.valid        = w_advance;
    assign w_req.kind         = r_s1_word.kind;
    assign w_req.task_id      = r_s1_word.task_id;
    assign w_req.timestamp_us = w_time.timestamp_us;

    ttp_task_table u_task_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_out_word.timestamp_us    = w_time.timestamp_us;
        n_out_word.task_time       = w_rsp.task_time;
        n_out_word.peak_time       = w_rsp.peak_time;
        n_out_word.slow_period_due = w_time.slow_period_due;
        n_out_word.accepted        = w_rsp.accepted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_slow <= ttp_pkg::SLOW_RESET;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_ticks_per_slow <= pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_load) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_s1_word <= i_in_word;
            r_s1_frac <= w_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef NO_ASSERTIONS
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_advance |=> r_s1_valid && $stable(r_s1_word))
        else $error("input stage lost or changed a blocked word");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a full pipeline");

    a_due_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && n_out_word.slow_period_due |-> r_s1_word.kind == ttp_pkg::KIND_TICK)
        else $error("slow period flag on a task word");

    a_accept_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && n_out_word.accepted
            |-> r_s1_word.kind == ttp_pkg::KIND_START || r_s1_word.kind == ttp_pkg::KIND_END)
        else $error("accepted flag on a tick or unused kind");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !n_out_word.accepted
            |-> n_out_word.task_time == 32'd0 && n_out_word.peak_time == 32'd0)
        else $error("rejected word carries task timing");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && n_out_word.accepted |-> n_out_word.peak_time >= n_out_word.task_time)
        else $error("peak below current task time");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_task_time_profiler_unit.sv
// Self-checking testbench for the task time profiler: directed table, then random words.
module tb_task_time_profiler_unit;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int N_DIRECTED = 24;
    localparam int N_PHASES = 5;

    typedef struct packed {
        ttp_pkg::t_in_word  word;
        logic               fixed;
        ttp_pkg::t_out_word want;
    } t_row;

    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{ttp_pkg::KIND_START, 4'd0, 13'd0, 1'b0}, 1'b1,
          '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{'{ttp_pkg::KIND_END, 4'd0, 13'd7499, 1'b0}, 1'b1,
          '{32'd999, 32'd999, 32'd999, 1'b0, 1'b1}},
        '{'{ttp_pkg::KIND_TICK, 4'd0, 13'd0, 1'b1}, 1'b1,
          '{32'd2000, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{'{ttp_pkg::KIND_START, 4'd15, 13'd8191, 1'b0}, 1'b1,
          '{32'd2092, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{'{KIND_SPARE, 4'd5, 13'd100, 1'b0}, 1'b1,
          '{32'd1013, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{'{ttp_pkg::KIND_START, 4'd3, 13'd3750, 1'b0}, 1'b1,
          '{32'd1500, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{'{ttp_pkg::KIND_END, 4'd3, 13'd8191, 1'b1}, 1'b1,
          '{32'd2000, 32'd500, 32'd500, 1'b0, 1'b1}},
        '{'{ttp_pkg::KIND_END, 4'd1, 13'd0, 1'b0}, 1'b1,
          '{32'd1000, 32'd1000, 32'd1000, 1'b0, 1'b1}},
        '{'{ttp_pkg::KIND_START, 4'd2, 13'd0, 1'b1}, 1'b1,
          '{32'd2000, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{'{ttp_pkg::KIND_END, 4'd4, 13'd1, 1'b0}, 1'b1,
          '{32'd1000, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{'{ttp_pkg::KIND_TICK, 4'd10, 13'd1, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_TICK, 4'd5, 13'd2730, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_TICK, 4'd15, 13'd5461, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_TICK, 4'd0, 13'd7499, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_TICK, 4'd3, 13'd7500, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_TICK, 4'd12, 13'd8191, 1'b1}, 1'b0, '0},
        '{'{ttp_pkg::KIND_TICK, 4'd9, 13'd4096, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_TICK, 4'd6, 13'd0, 1'b1}, 1'b0, '0},
        '{'{ttp_pkg::KIND_TICK, 4'd1, 13'd0, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_END, 4'd2, 13'd0, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_START, 4'd1, 13'd7499, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_END, 4'd1, 13'd0, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_END, 4'd0, 13'd4096, 1'b0}, 1'b0, '0},
        '{'{ttp_pkg::KIND_START, 4'd0, 13'd5461, 1'b1}, 1'b0, '0}
    };

    localparam logic [7:0] SLOW_SETTINGS [N_PHASES] = '{8'd255, 8'd1, 8'd0, 8'd0, 8'd10};
    localparam int PHASE_WORDS [N_PHASES] = '{320, 250, 250, 250, 250};
    localparam int PHASE_TICK_PCT [N_PHASES] = '{90, 35, 35, 35, 35};

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    ttp_pkg::t_in_word              in_word = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    ttp_pkg::t_out_word             out_word;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [ttp_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    logic [31:0] ms_tick_count;
    logic [7:0]  sub_tick;
    logic [31:0] task_start [ttp_pkg::TASKS];
    logic [31:0] task_peak [ttp_pkg::TASKS];
    logic [7:0]  slow_limit;

    ttp_pkg::t_out_word timing_results_q [$];
    ttp_pkg::t_out_word oldest_timing;
    int        burst_left = 0;
    logic      stall_on = 1'b0;
    int        stall_run = 0;
    int        cycles = 0;
    int        n_errors = 0;
    int        n_words = 0;
    int        n_accepted = 0;
    int        n_pulses = 0;
    int        n_settings = 0;

    task_time_profiler_unit u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_word    (in_word),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_word   (out_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] stamp_usec(ttp_pkg::t_in_word w);
        longint unsigned c;
        c = w.match_pending ? 64'(ttp_pkg::TIMER_PERIOD) : 64'(w.timer_count);
        return 32'(64'(ms_tick_count) * 64'd1000
                   + c * 64'd1000 / 64'(ttp_pkg::TIMER_PERIOD));
    endfunction

    function automatic ttp_pkg::t_out_word profile_item(ttp_pkg::t_in_word w);
        ttp_pkg::t_out_word r;
        logic [ttp_pkg::TASK_IW-1:0] t;
        r = '0;
        t = ttp_pkg::TASK_IW'(w.task_id);
        if (w.kind == ttp_pkg::KIND_TICK) begin
            ms_tick_count = ms_tick_count + 32'd1;
            sub_tick = sub_tick + 8'd1;
            if (sub_tick >= slow_limit) begin
                sub_tick = 8'd0;
                r.slow_period_due = 1'b1;
            end
            r.timestamp_us = stamp_usec(w);
        end else begin
            r.timestamp_us = stamp_usec(w);
            if ((w.kind == ttp_pkg::KIND_START || w.kind == ttp_pkg::KIND_END)
                    && w.task_id < ttp_pkg::TASKS) begin
                r.accepted = 1'b1;
                if (w.kind == ttp_pkg::KIND_START) begin
                    task_start[t] = r.timestamp_us;
                end else begin
                    r.task_time = r.timestamp_us - task_start[t];
                    if (r.task_time > task_peak[t]) begin
                        task_peak[t] = r.task_time;
                    end
                end
                r.peak_time = task_peak[t];
            end
        end
        return r;
    endfunction

    function automatic ttp_pkg::t_in_word random_item(int tick_pct);
        ttp_pkg::t_in_word w;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < tick_pct) begin
            w.kind = ttp_pkg::KIND_TICK;
        end else if (roll < tick_pct + 4) begin
            w.kind = KIND_SPARE;
        end else begin
            w.kind = ($urandom_range(0, 1) == 0) ? ttp_pkg::KIND_START : ttp_pkg::KIND_END;
        end
        w.task_id = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(ttp_pkg::TASKS, 15))
                                                 : 4'($urandom_range(0, ttp_pkg::TASKS - 1));
        w.timer_count = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(7500, 8191))
                                                     : 13'($urandom_range(0, 7499));
        w.match_pending = ($urandom_range(0, 7) == 0);
        return w;
    endfunction

    task automatic send_item(input ttp_pkg::t_in_word w, input logic fixed,
                             input ttp_pkg::t_out_word want);
        int gap;
        ttp_pkg::t_out_word predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
            stall_on <= ($urandom_range(0, 3) != 0);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = profile_item(w);
        timing_results_q.push_back(fixed ? want : predicted);
        n_words++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (timing_results_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_slow_limit(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {ttp_pkg::REG_TICKS_PER_SLOW, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        slow_limit = value;
        n_settings++;
    endtask

    // hold stall for runs of random length; drop it outright in quiet bursts
    always @(posedge clk) begin
        if (!stall_on) begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run == 0) begin
            stall_run <= $urandom_range(1, 8);
            out_stall <= ($urandom_range(0, 2) == 0);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (timing_results_q.size() == 0) begin
                $error("result word with nothing outstanding: %h", out_word);
                n_errors++;
            end else begin
                oldest_timing = timing_results_q.pop_front();
                if (out_word.timestamp_us !== oldest_timing.timestamp_us) begin
                    $error("timestamp_us: expected %0d, got %0d",
                           oldest_timing.timestamp_us, out_word.timestamp_us);
                    n_errors++;
                end
                if (out_word.task_time !== oldest_timing.task_time) begin
                    $error("task_time: expected %0d, got %0d",
                           oldest_timing.task_time, out_word.task_time);
                    n_errors++;
                end
                if (out_word.peak_time !== oldest_timing.peak_time) begin
                    $error("peak_time: expected %0d, got %0d",
                           oldest_timing.peak_time, out_word.peak_time);
                    n_errors++;
                end
                if (out_word.slow_period_due !== oldest_timing.slow_period_due) begin
                    $error("slow_period_due: expected %0b, got %0b",
                           oldest_timing.slow_period_due, out_word.slow_period_due);
                    n_errors++;
                end
                if (out_word.accepted !== oldest_timing.accepted) begin
                    $error("accepted: expected %0b, got %0b",
                           oldest_timing.accepted, out_word.accepted);
                    n_errors++;
                end
                n_pulses += out_word.slow_period_due;
                n_accepted += out_word.accepted;
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, timing_results_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [7:0] setting;
        ms_tick_count = '0;
        sub_tick = '0;
        slow_limit = ttp_pkg::SLOW_RESET;
        for (int i = 0; i < ttp_pkg::TASKS; i++) begin
            task_start[i] = '0;
            task_peak[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
        end
        drain_results();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            setting = (ph == 3) ? 8'($urandom_range(2, 254)) : SLOW_SETTINGS[ph];
            write_slow_limit(setting);
            for (int k = 0; k < PHASE_WORDS[ph]; k++) begin
                if (k % 120 == 119) begin
                    drain_results();
                end
                send_item(random_item(PHASE_TICK_PCT[ph]), 1'b0, '0);
            end
            drain_results();
        end
        repeat (8) @(posedge clk);

        $display("covered %0d words over %0d slow-period settings (0, 1, 255 among them)",
                 n_words, n_settings);
        $display("saw %0d slow-period pulses and %0d accepted task words", n_pulses, n_accepted);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: task_time_profiler_unit.f
rtl/ttp_pkg.sv
rtl/ttp_frac.sv
rtl/ttp_timebase.sv
rtl/ttp_task_table.sv
rtl/task_time_profiler_unit.sv
dv/tb_task_time_profiler_unit.sv
